// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files of the RTT estimator.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/rtte_pkg.sv
// Package for the RTT estimator: opcodes, register indexes and fixed widths.
// No dependencies.
`default_nettype none

package rtte_pkg;

  typedef enum logic [1:0] {
    OP_UPDATE      = 2'd0,
    OP_SET_INITIAL = 2'd1,
    OP_RESET       = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_GRANULARITY   = 2'd0,
    CFG_MAX_ACK_DELAY = 2'd1,
    CFG_MAX_SAMPLE    = 2'd2
  } cfg_idx_t;

  localparam int unsigned CFG_W = 32;
  localparam int unsigned PTO_W = 35;

  localparam logic [CFG_W-1:0] GRANULARITY_RST   = 32'd1;
  localparam logic [CFG_W-1:0] MAX_ACK_DELAY_RST = 32'd25;
  localparam logic [CFG_W-1:0] MAX_SAMPLE_RST    = 32'hFFFF_FFFF;

  localparam logic [PTO_W-1:0] PTO_MAX = '1;

endpackage

`default_nettype wire

// File: hw/rtl/rtte_core.sv
// Next-state logic of the RTT estimator: sample filter, min tracking, ack delay
// adjustment and the smoothed/deviation EWMA, plus set-initial and reset. Depends on rtte_pkg.
`default_nettype none

module rtte_core
  import rtte_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic [1:0]            opcode,
  input  logic [TIME_WIDTH-1:0] sample,
  input  logic [TIME_WIDTH-1:0] delay,
  input  logic [CFG_W-1:0]      max_sample,
  input  logic                  init,
  input  logic [TIME_WIDTH-1:0] min_val,
  input  logic [TIME_WIDTH-1:0] latest_val,
  input  logic [TIME_WIDTH-1:0] smoothed_val,
  input  logic [TIME_WIDTH-1:0] deviation_val,
  output logic                  accepted,
  output logic                  init_nxt,
  output logic [TIME_WIDTH-1:0] min_nxt,
  output logic [TIME_WIDTH-1:0] latest_nxt,
  output logic [TIME_WIDTH-1:0] smoothed_nxt,
  output logic [TIME_WIDTH-1:0] deviation_nxt
);

  localparam int WW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

  logic                  sample_ok;
  logic [TIME_WIDTH-1:0] min_upd;
  logic [TIME_WIDTH-1:0] adj;
  logic [TIME_WIDTH-1:0] diff;
  logic [TIME_WIDTH+1:0] dev_sum;
  logic [TIME_WIDTH+2:0] smo_sum;

  assign sample_ok = (sample != '0) && (WW'(sample) <= WW'(max_sample));
  assign min_upd   = ((min_val == '0) || (min_val > sample)) ? sample : min_val;
  assign adj       = ((sample - min_upd) >= delay) ? (sample - delay) : sample;
  assign diff      = (smoothed_val > adj) ? (smoothed_val - adj) : (adj - smoothed_val);
  assign dev_sum   = {2'b00, deviation_val} + {1'b0, deviation_val, 1'b0} + {2'b00, diff};
  assign smo_sum   = {smoothed_val, 3'b000} - {3'b000, smoothed_val} + {3'b000, adj};

  always_comb begin
    accepted      = 1'b0;
    init_nxt      = init;
    min_nxt       = min_val;
    latest_nxt    = latest_val;
    smoothed_nxt  = smoothed_val;
    deviation_nxt = deviation_val;
    case (op_t'(opcode))
      OP_UPDATE: begin
        if (sample_ok) begin
          accepted   = 1'b1;
          min_nxt    = min_upd;
          latest_nxt = adj;
          if (!init) begin
            init_nxt      = 1'b1;
            smoothed_nxt  = adj;
            deviation_nxt = adj >> 1;
          end else begin
            smoothed_nxt  = smo_sum[TIME_WIDTH+2:3];
            deviation_nxt = dev_sum[TIME_WIDTH+1:2];
          end
        end
      end
      OP_SET_INITIAL: begin
        if (!init) begin
          accepted     = 1'b1;
          latest_nxt   = sample;
          smoothed_nxt = sample;
        end
      end
      OP_RESET: begin
        accepted      = 1'b1;
        min_nxt       = '0;
        latest_nxt    = '0;
        smoothed_nxt  = '0;
        deviation_nxt = '0;
      end
      default: begin
        accepted = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/rtt_estimator_pto_unit.sv
// QUIC RTT estimator with probe timeout: one result for every request, passing
// through an input register, then a result register, and a sustained rate of
// one request per clock while out_stall is not held. Probe timeouts are formed
// from the result register and the configuration. Depends on rtte_pkg,
// rtte_core and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rtt_estimator_pto_unit
  import rtte_pkg::*;
#(
  parameter int TIME_WIDTH  = 32,
  parameter int DEFAULT_RTT = 100
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_opcode,
  input  logic [31:0]      in_sample,
  input  logic [31:0]      in_ack_delay,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_accepted,
  output logic [PTO_W-1:0] out_pto_base,
  output logic [PTO_W-1:0] out_pto_with_ack_delay,
  output logic [31:0]      out_smoothed_rtt,
  output logic [31:0]      out_rtt_deviation,
  output logic [31:0]      out_min_rtt,
  output logic [31:0]      out_latest_rtt
);

  localparam int IW = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
  localparam int MW = ((TIME_WIDTH + 2) > CFG_W) ? (TIME_WIDTH + 2) : CFG_W;
  localparam int PW = ((MW + 2) > (PTO_W + 1)) ? (MW + 2) : (PTO_W + 1);

  logic [CFG_W-1:0] gran_r;
  logic [CFG_W-1:0] mad_r;
  logic [CFG_W-1:0] max_sample_r;

  logic        s1_valid_r;
  logic [1:0]  s1_opcode_r;
  logic [31:0] s1_sample_r;
  logic [31:0] s1_delay_r;

  logic                  init_r;
  logic [TIME_WIDTH-1:0] min_r;
  logic [TIME_WIDTH-1:0] latest_r;
  logic [TIME_WIDTH-1:0] smoothed_r;
  logic [TIME_WIDTH-1:0] deviation_r;

  logic                  init_nxt;
  logic [TIME_WIDTH-1:0] min_nxt;
  logic [TIME_WIDTH-1:0] latest_nxt;
  logic [TIME_WIDTH-1:0] smoothed_nxt;
  logic [TIME_WIDTH-1:0] deviation_nxt;
  logic                  accepted_nxt;

  logic                  out_valid_r;
  logic                  out_accepted_r;
  logic [TIME_WIDTH-1:0] out_smoothed_r;
  logic [TIME_WIDTH-1:0] out_deviation_r;
  logic [TIME_WIDTH-1:0] out_min_r;
  logic [TIME_WIDTH-1:0] out_latest_r;

  logic                  adv;
  logic [TIME_WIDTH-1:0] x_in;
  logic [TIME_WIDTH-1:0] delay_in;
  logic [PW-1:0]         var_w;
  logic [PW-1:0]         gran_w;
  logic [PW-1:0]         var_max;
  logic [PW-1:0]         base_w;
  logic [PW-1:0]         with_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gran_r       <= GRANULARITY_RST;
      mad_r        <= MAX_ACK_DELAY_RST;
      max_sample_r <= MAX_SAMPLE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRANULARITY:   gran_r       <= cfg_wdata;
        CFG_MAX_ACK_DELAY: mad_r        <= cfg_wdata;
        CFG_MAX_SAMPLE:    max_sample_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_opcode_r <= in_opcode;
      s1_sample_r <= in_sample;
      s1_delay_r  <= in_ack_delay;
    end
  end

  assign x_in     = TIME_WIDTH'(s1_sample_r[IW-1:0]);
  assign delay_in = TIME_WIDTH'(s1_delay_r[IW-1:0]);

  rtte_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .opcode        (s1_opcode_r),
    .sample        (x_in),
    .delay         (delay_in),
    .max_sample    (max_sample_r),
    .init          (init_r),
    .min_val       (min_r),
    .latest_val    (latest_r),
    .smoothed_val  (smoothed_r),
    .deviation_val (deviation_r),
    .accepted      (accepted_nxt),
    .init_nxt      (init_nxt),
    .min_nxt       (min_nxt),
    .latest_nxt    (latest_nxt),
    .smoothed_nxt  (smoothed_nxt),
    .deviation_nxt (deviation_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= 1'b0;
      min_r       <= '0;
      latest_r    <= '0;
      smoothed_r  <= '0;
      deviation_r <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        init_r      <= init_nxt;
        min_r       <= min_nxt;
        latest_r    <= latest_nxt;
        smoothed_r  <= smoothed_nxt;
        deviation_r <= deviation_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_accepted_r  <= accepted_nxt;
      out_smoothed_r  <= smoothed_nxt;
      out_deviation_r <= deviation_nxt;
      out_min_r       <= min_nxt;
      out_latest_r    <= latest_nxt;
    end
  end

  assign var_w   = PW'({out_deviation_r, 2'b00});
  assign gran_w  = PW'(gran_r);
  assign var_max = (gran_w > var_w) ? gran_w : var_w;
  assign base_w  = PW'(out_smoothed_r) + var_max;
  assign with_w  = base_w + PW'(mad_r);

  always_comb begin
    if (out_smoothed_r == '0) begin
      out_pto_base           = PTO_W'(DEFAULT_RTT * 2);
      out_pto_with_ack_delay = PTO_W'(DEFAULT_RTT * 2);
    end else begin
      out_pto_base           = (base_w > PW'(PTO_MAX)) ? PTO_MAX : base_w[PTO_W-1:0];
      out_pto_with_ack_delay = (with_w > PW'(PTO_MAX)) ? PTO_MAX : with_w[PTO_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_accepted_r;
  assign out_smoothed_rtt  = 32'(out_smoothed_r[IW-1:0]);
  assign out_rtt_deviation = 32'(out_deviation_r[IW-1:0]);
  assign out_min_rtt       = 32'(out_min_r[IW-1:0]);
  assign out_latest_rtt    = 32'(out_latest_r[IW-1:0]);

  `ASSERT_NEXT(a_init_sticky, init_r, init_r)
  `ASSERT_IMPLY(a_stall_only_full, in_stall, s1_valid_r)
  `ASSERT_IMPLY(a_pto_order, out_valid_r, out_pto_base <= out_pto_with_ack_delay)

endmodule

`default_nettype wire
